### rtl/stdb_pkg.sv
package stdb_pkg;

	localparam int FRAC_BITS = 8;

	localparam int SCALE_W = 12;
	localparam int PX_W    = 14;
	localparam int MM_W    = 12;
	localparam int PPI_W   = 10;
	localparam int DELAY_W = 16;
	localparam int CONF_W  = 8;
	localparam int USR_W   = FRAC_BITS + 2;
	localparam int PROD_W  = SCALE_W + USR_W - FRAC_BITS;

	// divider operands: px*254 << FRAC over mm*10*ppi
	localparam int NUM_W = PX_W + 8 + FRAC_BITS;
	localparam int DEN_W = MM_W + 4 + PPI_W;
	localparam int QW    = SCALE_W;
	localparam int DSH_W = DEN_W + QW;
	localparam int CNT_W = $clog2(QW + 1);

	localparam logic [SCALE_W-1:0] SCALE_MAX = {SCALE_W{1'b1}};
	localparam logic [SCALE_W-1:0] ONE_Q     = SCALE_W'(1 << FRAC_BITS);
	localparam logic [USR_W-1:0]   USR_LO    = USR_W'(1 << (FRAC_BITS - 1));
	localparam logic [USR_W-1:0]   USR_HI    = USR_W'(1 << (FRAC_BITS + 1));
	localparam logic [MM_W-1:0]    MM_MIN    = MM_W'(50);

	// quarter rounding
	localparam int RQ_SH = FRAC_BITS - 2;
	localparam logic [SCALE_W:0]   RQ_HALF = (SCALE_W + 1)'(1 << (RQ_SH - 1));
	localparam logic [SCALE_W-1:0] RQ_MAX  = SCALE_W'((4095 >> RQ_SH) << RQ_SH);

	// register indexes
	localparam logic [2:0] REG_SCALE_MIN   = 3'd0;
	localparam logic [2:0] REG_SCALE_MAX   = 3'd1;
	localparam logic [2:0] REG_REF_PPI     = 3'd2;
	localparam logic [2:0] REG_DELAY_TICKS = 3'd3;
	localparam logic [2:0] REG_MIN_CONFS   = 3'd4;

	localparam logic [SCALE_W-1:0] RST_SCALE_MIN = SCALE_W'(128);
	localparam logic [SCALE_W-1:0] RST_SCALE_MAX = SCALE_W'(1024);
	localparam logic [PPI_W-1:0]   RST_REF_PPI   = PPI_W'(96);
	localparam logic [DELAY_W-1:0] RST_DELAY     = DELAY_W'(700);
	localparam logic [CONF_W-1:0]  RST_MIN_CONFS = CONF_W'(2);

	typedef enum logic [1:0] {
		OP_MEAS = 2'd0,
		OP_TICK = 2'd1,
		OP_OS   = 2'd2,
		OP_USER = 2'd3
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [SCALE_W-1:0] os_scale;
		logic [USR_W-1:0]   user_mult;
		logic [PX_W-1:0]    px;
		logic [MM_W-1:0]    mm;
	} item_t;

	typedef struct packed {
		logic [SCALE_W-1:0] scale_min;
		logic [SCALE_W-1:0] scale_max;
		logic [PPI_W-1:0]   ref_ppi;
		logic [DELAY_W-1:0] delay_ticks;
		logic [CONF_W-1:0]  min_confs;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [SCALE_W-1:0] quot;
	} div_rsp_t;

endpackage

### rtl/stdb_fifo.sv
module stdb_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  stdb_pkg::item_t    wdata,
	output logic               full,
	input  logic               pop,
	output logic               empty,
	output stdb_pkg::item_t    rdata
);

	stdb_pkg::item_t mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/stdb_front.sv
module stdb_front (
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [55:0]          s_tdata,
	input  logic [1:0]           s_tuser,
	input  logic                 q_full,
	output logic                 q_push,
	output stdb_pkg::item_t      q_item
);

	logic [stdb_pkg::SCALE_W-1:0] um;

	assign s_tready = ~q_full;
	assign q_push   = s_tvalid & ~q_full;
	assign um       = s_tdata[23:12];

	always_comb begin
		q_item          = '0;
		q_item.op       = stdb_pkg::op_t'(s_tuser);
		q_item.os_scale = s_tdata[11:0];
		q_item.px       = s_tdata[37:24];
		q_item.mm       = s_tdata[49:38];
		// clamp the user multiplier to half..double
		if (32'(um) < 32'(stdb_pkg::USR_LO)) begin
			q_item.user_mult = stdb_pkg::USR_LO;
		end else if (32'(um) > 32'(stdb_pkg::USR_HI)) begin
			q_item.user_mult = stdb_pkg::USR_HI;
		end else begin
			q_item.user_mult = stdb_pkg::USR_W'(um);
		end
	end

endmodule

### rtl/stdb_div.sv
module stdb_div (
	input  logic                clk,
	input  logic                arst_n,
	input  stdb_pkg::div_req_t  req,
	output stdb_pkg::div_rsp_t  rsp
);

	logic [stdb_pkg::NUM_W-1:0]   rem_q;
	logic [stdb_pkg::DSH_W-1:0]   dsh_q;
	logic [stdb_pkg::QW-1:0]      quot_q;
	logic [stdb_pkg::CNT_W-1:0]   cnt_q;
	logic                         run_q;
	logic                         ovf_q;
	logic                         done_q;
	logic                         ge;

	assign ge = (stdb_pkg::DSH_W'(rem_q) >= dsh_q);

	assign rsp.done = done_q;
	assign rsp.quot = ovf_q ? stdb_pkg::SCALE_MAX : quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				ovf_q <= 1'b0;
				cnt_q <= stdb_pkg::CNT_W'(stdb_pkg::QW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				// first step only checks for a quotient past the top
				if (cnt_q == stdb_pkg::CNT_W'(stdb_pkg::QW) && ge) begin
					ovf_q  <= 1'b1;
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.num;
			dsh_q  <= {req.den, {stdb_pkg::QW{1'b0}}};
			quot_q <= '0;
		end else if (run_q) begin
			dsh_q <= dsh_q >> 1;
			if (cnt_q != stdb_pkg::CNT_W'(stdb_pkg::QW)) begin
				quot_q <= {quot_q[stdb_pkg::QW-2:0], ge};
				if (ge) begin
					rem_q <= rem_q - stdb_pkg::NUM_W'(dsh_q);
				end
			end
		end
	end

endmodule

### rtl/stdb_back.sv
module stdb_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  stdb_pkg::cfg_t       cfg,
	input  logic                 q_empty,
	input  stdb_pkg::item_t      q_item,
	output logic                 q_pop,
	output stdb_pkg::div_req_t   div_req,
	input  stdb_pkg::div_rsp_t   div_rsp,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [23:0]          m_tdata,
	output logic [1:0]           m_tuser
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_START = 7'b0000010,
		ST_DIV   = 7'b0000100,
		ST_MON   = 7'b0001000,
		ST_MUL   = 7'b0010000,
		ST_UPD   = 7'b0100000,
		ST_TICK  = 7'b1000000
	} state_t;

	state_t                                       state_q;
	stdb_pkg::item_t                              item_q;
	logic [stdb_pkg::SCALE_W-1:0]                 os_q;
	logic [stdb_pkg::USR_W-1:0]                   user_q;
	logic [stdb_pkg::SCALE_W-1:0]                 phys_q;
	logic [stdb_pkg::SCALE_W-1:0]                 mon_q;
	logic [stdb_pkg::PROD_W-1:0]                  prod_q;
	logic [stdb_pkg::SCALE_W-1:0]                 eff_q;
	logic [stdb_pkg::SCALE_W-1:0]                 cmon_q;
	logic [stdb_pkg::SCALE_W-1:0]                 cand_q;
	logic [stdb_pkg::SCALE_W-1:0]                 cand_mon_q;
	logic                                         cv_q;
	logic [stdb_pkg::CONF_W-1:0]                  conf_q;
	logic [stdb_pkg::DELAY_W-1:0]                 age_q;
	logic                                         m_valid_q;
	logic [stdb_pkg::SCALE_W-1:0]                 out_eff_q;
	logic [stdb_pkg::SCALE_W-1:0]                 out_mon_q;
	logic                                         out_chg_q;
	logic                                         out_pend_q;

	logic                                         out_free;
	logic                                         need_div;
	logic [stdb_pkg::SCALE_W-1:0]                 mon_in;
	logic [stdb_pkg::SCALE_W:0]                   rq_sum;
	logic [stdb_pkg::SCALE_W-1:0]                 rq_val;
	logic [stdb_pkg::PROD_W-1:0]                  p_lo;
	logic [stdb_pkg::PROD_W-1:0]                  p_hi;
	logic [stdb_pkg::SCALE_W-1:0]                 tgt;
	logic                                         cv_n;
	logic [stdb_pkg::SCALE_W-1:0]                 cs_n;
	logic [stdb_pkg::SCALE_W-1:0]                 cm_n;
	logic [stdb_pkg::CONF_W-1:0]                  conf_n;
	logic [stdb_pkg::DELAY_W-1:0]                 age_n;
	logic [stdb_pkg::CONF_W-1:0]                  need;
	logic                                         commit;
	logic                                         finish;
	logic [stdb_pkg::USR_W+stdb_pkg::SCALE_W-1:0] prod_full;

	assign out_free = ~m_valid_q | m_tready;
	assign q_pop    = (state_q == ST_IDLE) & ~q_empty & out_free;
	assign finish   = (state_q == ST_UPD) | (state_q == ST_TICK);
	assign need_div = (item_q.mm >= stdb_pkg::MM_MIN) & (cfg.ref_ppi != '0);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {out_mon_q, out_eff_q};
	assign m_tuser  = {out_pend_q, out_chg_q};

	always_comb begin
		div_req       = '0;
		div_req.start = (state_q == ST_START) & need_div;
		div_req.num   = (stdb_pkg::NUM_W'(item_q.px) * stdb_pkg::NUM_W'(254))
		                << stdb_pkg::FRAC_BITS;
		div_req.den   = stdb_pkg::DEN_W'(item_q.mm) * stdb_pkg::DEN_W'(cfg.ref_ppi)
		                * stdb_pkg::DEN_W'(10);
	end

	// monitor part: larger of OS and physical scale, rounded to a quarter
	always_comb begin
		mon_in = (os_q > phys_q) ? os_q : phys_q;
		rq_sum = {1'b0, mon_in} + stdb_pkg::RQ_HALF;
		rq_sum = (rq_sum >> stdb_pkg::RQ_SH) << stdb_pkg::RQ_SH;
		rq_val = (rq_sum > (stdb_pkg::SCALE_W + 1)'(stdb_pkg::RQ_MAX)) ?
		         stdb_pkg::RQ_MAX : stdb_pkg::SCALE_W'(rq_sum);
	end

	assign prod_full = (stdb_pkg::USR_W + stdb_pkg::SCALE_W)'(mon_q)
	                 * (stdb_pkg::USR_W + stdb_pkg::SCALE_W)'(user_q);

	always_comb begin
		p_lo = (prod_q < stdb_pkg::PROD_W'(cfg.scale_min)) ?
		       stdb_pkg::PROD_W'(cfg.scale_min) : prod_q;
		p_hi = (p_lo > stdb_pkg::PROD_W'(cfg.scale_max)) ?
		       stdb_pkg::PROD_W'(cfg.scale_max) : p_lo;
		tgt  = stdb_pkg::SCALE_W'(p_hi);

		cv_n   = cv_q;
		cs_n   = cand_q;
		cm_n   = cand_mon_q;
		conf_n = conf_q;
		age_n  = age_q;
		if (state_q == ST_TICK) begin
			if (cv_q && age_q != '1) begin
				age_n = age_q + 1'b1;
			end
		end else if (tgt == eff_q) begin
			// target already committed: drop any candidate
			cv_n   = 1'b0;
			cs_n   = '0;
			conf_n = '0;
		end else if (!cv_q || tgt != cand_q) begin
			cv_n   = 1'b1;
			cs_n   = tgt;
			cm_n   = mon_q;
			age_n  = '0;
			conf_n = stdb_pkg::CONF_W'(1);
		end else if (conf_q != '1) begin
			conf_n = conf_q + 1'b1;
		end

		need = (cfg.min_confs == '0) ? stdb_pkg::CONF_W'(1) : cfg.min_confs;
		case (item_q.op) inside
			stdb_pkg::OP_OS, stdb_pkg::OP_USER: commit = cv_n;
			default: commit = cv_n & (conf_n >= need) & (age_n >= cfg.delay_ticks);
		endcase
		if (state_q == ST_TICK) begin
			commit = cv_n & (conf_n >= need) & (age_n >= cfg.delay_ticks);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_valid_q  <= 1'b0;
			os_q       <= stdb_pkg::ONE_Q;
			user_q     <= stdb_pkg::USR_W'(stdb_pkg::ONE_Q);
			phys_q     <= '0;
			eff_q      <= stdb_pkg::ONE_Q;
			cmon_q     <= stdb_pkg::ONE_Q;
			cand_q     <= '0;
			cand_mon_q <= stdb_pkg::ONE_Q;
			cv_q       <= 1'b0;
			conf_q     <= '0;
			age_q      <= '0;
		end else begin
			if (finish) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end

			unique case (state_q) inside
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= (q_item.op == stdb_pkg::OP_TICK) ? ST_TICK : ST_START;
					end
				end
				ST_START: begin
					if (item_q.op == stdb_pkg::OP_OS) begin
						os_q <= item_q.os_scale;
					end
					if (item_q.op == stdb_pkg::OP_USER) begin
						user_q <= item_q.user_mult;
					end
					if (item_q.mm < stdb_pkg::MM_MIN) begin
						phys_q  <= '0;
						state_q <= ST_MON;
					end else if (cfg.ref_ppi == '0) begin
						phys_q  <= stdb_pkg::SCALE_MAX;
						state_q <= ST_MON;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						phys_q  <= div_rsp.quot;
						state_q <= ST_MON;
					end
				end
				ST_MON: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_UPD;
				ST_UPD, ST_TICK: begin
					state_q <= ST_IDLE;
					age_q   <= age_n;
					if (commit) begin
						eff_q  <= cs_n;
						cmon_q <= cm_n;
						cv_q   <= 1'b0;
						cand_q <= '0;
						conf_q <= '0;
					end else begin
						cv_q   <= cv_n;
						cand_q <= cs_n;
						conf_q <= conf_n;
					end
					cand_mon_q <= cm_n;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
		if (state_q == ST_MON) begin
			mon_q <= rq_val;
		end
		if (state_q == ST_MUL) begin
			prod_q <= stdb_pkg::PROD_W'(prod_full >> stdb_pkg::FRAC_BITS);
		end
		if (finish) begin
			out_eff_q  <= commit ? cs_n : eff_q;
			out_mon_q  <= commit ? cm_n : cmon_q;
			out_chg_q  <= commit;
			out_pend_q <= commit ? 1'b0 : cv_n;
		end
	end

endmodule

### rtl/scale_target_debouncer_unit.sv
// Scale target debouncer.
// Input stream (s_*): one transaction per item; s_tuser carries the opcode
// (measurement, tick, OS scale event, user scale set), s_tdata the scales and
// the monitor geometry. Output stream (m_*): exactly one transaction per input
// item, in order: committed effective scale and monitor part in m_tdata,
// scale-changed and pending flags in m_tuser.
// Configuration goes through the APB port; write only while the block is idle.
// A tick goes from the queue through the tick state to m_tvalid. Other items
// pass start, monitor, multiply and update; with a known width they wait after
// start for the 13-step restoring divider for the physical scale, which ends
// after its first step if the quotient overflows. An unknown width or a zero
// reference density skips the divider. Items are handled one at a time.
// A 2-entry queue sits between the input side and the execution side, so
// input keeps being accepted while a result waits in the output register;
// a stalled m_tready holds the result and, once the queue fills, s_tready.
// Reset: the OS, user, effective and monitor scales return to 1.0 and the
// physical scale to zero, no candidate is pending, registers take their defaults and both streams are empty.
module scale_target_debouncer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // os_scale, user_multiplier, monitor_width_px, monitor_width_mm
	input  logic [1:0]  s_tuser,  // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // out_effective_scale, out_monitor_part
	output logic [1:0]  m_tuser   // scale_changed, pending_active
);

	stdb_pkg::cfg_t      cfg_q;
	stdb_pkg::item_t     push_item;
	stdb_pkg::item_t     pop_item;
	stdb_pkg::div_req_t  div_req;
	stdb_pkg::div_rsp_t  div_rsp;
	logic                q_push;
	logic                q_pop;
	logic                q_full;
	logic                q_empty;
	logic                wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_min   <= stdb_pkg::RST_SCALE_MIN;
			cfg_q.scale_max   <= stdb_pkg::RST_SCALE_MAX;
			cfg_q.ref_ppi     <= stdb_pkg::RST_REF_PPI;
			cfg_q.delay_ticks <= stdb_pkg::RST_DELAY;
			cfg_q.min_confs   <= stdb_pkg::RST_MIN_CONFS;
		end else if (wr_en) begin
			unique case (paddr[4:2])
				stdb_pkg::REG_SCALE_MIN:   cfg_q.scale_min   <= pwdata[11:0];
				stdb_pkg::REG_SCALE_MAX:   cfg_q.scale_max   <= pwdata[11:0];
				stdb_pkg::REG_REF_PPI:     cfg_q.ref_ppi     <= pwdata[9:0];
				stdb_pkg::REG_DELAY_TICKS: cfg_q.delay_ticks <= pwdata[15:0];
				stdb_pkg::REG_MIN_CONFS:   cfg_q.min_confs   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			stdb_pkg::REG_SCALE_MIN:   prdata = 32'(cfg_q.scale_min);
			stdb_pkg::REG_SCALE_MAX:   prdata = 32'(cfg_q.scale_max);
			stdb_pkg::REG_REF_PPI:     prdata = 32'(cfg_q.ref_ppi);
			stdb_pkg::REG_DELAY_TICKS: prdata = 32'(cfg_q.delay_ticks);
			stdb_pkg::REG_MIN_CONFS:   prdata = 32'(cfg_q.min_confs);
			default:                   prdata = '0;
		endcase
	end

	stdb_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (push_item)
	);

	stdb_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (push_item),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (pop_item)
	);

	stdb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	stdb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_item   (pop_item),
		.q_pop    (q_pop),
		.div_req  (div_req),
		.div_rsp  (div_rsp),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

### verif/tb_scale_target_debouncer_unit.sv
module tb_scale_target_debouncer_unit;

	localparam int STALL_LIMIT = 5000;

	typedef struct {
		logic [11:0] eff;
		logic [11:0] mon;
		logic        changed;
		logic        pending;
	} scale_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;  // os_scale, user_multiplier, monitor_width_px, monitor_width_mm
	logic [1:0]  s_tuser = '0;  // opcode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;  // out_effective_scale, out_monitor_part
	logic [1:0]  m_tuser;  // scale_changed, pending_active

	scale_target_debouncer_unit dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #2 clk = ~clk;

	// configuration copy
	logic [11:0] cfg_min, cfg_max;
	logic [9:0]  cfg_ppi;
	logic [15:0] cfg_delay;
	logic [7:0]  cfg_confs;

	// debouncer state copy
	logic [11:0] st_os, st_phys, st_user, st_eff, st_mon;
	logic [11:0] cand_scale, cand_mon;
	logic        cand_valid;
	logic [7:0]  cand_confs;
	logic [15:0] cand_age;

	scale_result_t predicted_scales[$];
	int err_count = 0;
	int results_seen = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int rx_hold_req = 0;
	int stall_cycles = 0;

	function automatic void reset_scale_state();
		cfg_min = stdb_pkg::RST_SCALE_MIN;
		cfg_max = stdb_pkg::RST_SCALE_MAX;
		cfg_ppi = stdb_pkg::RST_REF_PPI;
		cfg_delay = stdb_pkg::RST_DELAY;
		cfg_confs = stdb_pkg::RST_MIN_CONFS;
		st_os = stdb_pkg::ONE_Q;
		st_phys = '0;
		st_user = stdb_pkg::ONE_Q;
		st_eff = stdb_pkg::ONE_Q;
		st_mon = stdb_pkg::ONE_Q;
		cand_scale = '0;
		cand_mon = stdb_pkg::ONE_Q;
		cand_valid = 1'b0;
		cand_confs = '0;
		cand_age = '0;
	endfunction

	function automatic logic [11:0] physical_scale(logic [13:0] px, logic [11:0] mm);
		longint unsigned num, den, quo;
		if (mm < 50) return '0;
		if (cfg_ppi == 0) return 12'hFFF;
		num = (longint'(px) * 254) << stdb_pkg::FRAC_BITS;
		den = longint'(mm) * 10 * longint'(cfg_ppi);
		quo = num / den;
		return (quo > 4095) ? 12'hFFF : quo[11:0];
	endfunction

	function automatic logic [11:0] quarter_round(logic [11:0] v);
		int unsigned sh, r;
		sh = stdb_pkg::FRAC_BITS - 2;
		r = ((int'(v) + (1 << (sh - 1))) >> sh) << sh;
		if (r > 4095) r = (4095 >> sh) << sh;
		return r[11:0];
	endfunction

	function automatic void refresh_target(logic [13:0] px, logic [11:0] mm);
		logic [11:0] mon, tgt;
		int unsigned prod;
		st_phys = physical_scale(px, mm);
		mon = quarter_round((st_os > st_phys) ? st_os : st_phys);
		prod = (int'(mon) * int'(st_user)) >> stdb_pkg::FRAC_BITS;
		if (prod < cfg_min) prod = cfg_min;
		if (prod > cfg_max) prod = cfg_max;
		tgt = prod[11:0];
		if (tgt == st_eff) begin
			cand_valid = 1'b0;
			cand_scale = '0;
			cand_confs = '0;
			return;
		end
		if (!cand_valid || tgt != cand_scale) begin
			cand_valid = 1'b1;
			cand_scale = tgt;
			cand_mon = mon;
			cand_age = '0;
			cand_confs = 8'd1;
		end else if (cand_confs != 8'hFF) begin
			cand_confs++;
		end
	endfunction

	function automatic logic apply_commit();
		if (!cand_valid) return 1'b0;
		st_eff = cand_scale;
		st_mon = cand_mon;
		cand_valid = 1'b0;
		cand_scale = '0;
		cand_confs = '0;
		return 1'b1;
	endfunction

	function automatic logic debounced_commit();
		logic [7:0] need;
		need = (cfg_confs == 0) ? 8'd1 : cfg_confs;
		if (!cand_valid || cand_confs < need || cand_age < cfg_delay) return 1'b0;
		return apply_commit();
	endfunction

	function automatic scale_result_t predict_scale_step(stdb_pkg::op_t op, logic [11:0] os,
			logic [11:0] um, logic [13:0] px, logic [11:0] mm);
		scale_result_t res;
		logic chg;
		chg = 1'b0;
		case (op)
			stdb_pkg::OP_MEAS: begin
				refresh_target(px, mm);
				chg = debounced_commit();
			end
			stdb_pkg::OP_TICK: begin
				if (cand_valid && cand_age != 16'hFFFF) cand_age++;
				chg = debounced_commit();
			end
			stdb_pkg::OP_OS: begin
				st_os = os;
				refresh_target(px, mm);
				chg = apply_commit();
			end
			default: begin
				if (um < stdb_pkg::USR_LO) st_user = 12'(stdb_pkg::USR_LO);
				else if (um > stdb_pkg::USR_HI) st_user = 12'(stdb_pkg::USR_HI);
				else st_user = um;
				refresh_target(px, mm);
				chg = apply_commit();
			end
		endcase
		res.eff = st_eff;
		res.mon = st_mon;
		res.changed = chg;
		res.pending = cand_valid;
		return res;
	endfunction

	function automatic void report_field(string name, int idx, logic [11:0] exp_v,
			logic [11:0] act_v);
		if (exp_v === act_v) return;
		err_count++;
		$display("%0t: result %0d %s mismatch: expected %0d, got %0d",
			$time, idx, name, exp_v, act_v);
	endfunction

	// result checker and output-side flow control
	initial begin
		scale_result_t exp_r;
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (predicted_scales.size() == 0) begin
					err_count++;
					$display("%0t: unexpected result: expected none, got tdata=%h tuser=%b",
						$time, m_tdata, m_tuser);
				end else begin
					exp_r = predicted_scales.pop_front();
					report_field("effective scale", results_seen, exp_r.eff, m_tdata[11:0]);
					report_field("monitor part", results_seen, exp_r.mon, m_tdata[23:12]);
					report_field("scale changed", results_seen, 12'(exp_r.changed),
						12'(m_tuser[0]));
					report_field("pending", results_seen, 12'(exp_r.pending),
						12'(m_tuser[1]));
				end
				results_seen++;
			end
			if (rx_hold_req > 0) begin
				hold_left = rx_hold_req;
				rx_hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// watchdog: no transaction for too long while work is outstanding
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else if (s_tvalid || predicted_scales.size() != 0)
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("scale_target_debouncer_unit regression: fail");
			$finish;
		end
	end

	task automatic send_scale_item(stdb_pkg::op_t op, logic [11:0] os, logic [11:0] um,
			logic [13:0] px, logic [11:0] mm);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {6'b0, mm, px, um, os};
		do @(posedge clk); while (!s_tready);
		predicted_scales.push_back(predict_scale_step(op, os, um, px, mm));
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_random_item(stdb_pkg::op_t op);
		send_scale_item(op, 12'($urandom), 12'($urandom), 14'($urandom), 12'($urandom));
	endtask

	// drop valid and hold until every outstanding result is back
	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (predicted_scales.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			stdb_pkg::REG_SCALE_MIN:   cfg_min = val[11:0];
			stdb_pkg::REG_SCALE_MAX:   cfg_max = val[11:0];
			stdb_pkg::REG_REF_PPI:     cfg_ppi = val[9:0];
			stdb_pkg::REG_DELAY_TICKS: cfg_delay = val[15:0];
			stdb_pkg::REG_MIN_CONFS:   cfg_confs = val[7:0];
			default: ;
		endcase
		// read back
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== val) begin
			err_count++;
			$display("%0t: register %0d readback mismatch: expected %h, got %h",
				$time, idx, val, prdata);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(int smin, int smax, int ppi, int delay, int confs);
		wait_drain();
		write_reg(stdb_pkg::REG_SCALE_MIN, smin);
		write_reg(stdb_pkg::REG_SCALE_MAX, smax);
		write_reg(stdb_pkg::REG_REF_PPI, ppi);
		write_reg(stdb_pkg::REG_DELAY_TICKS, delay);
		write_reg(stdb_pkg::REG_MIN_CONFS, confs);
	endtask

	task automatic set_idling(int tx_pct, int rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
	endtask

	task automatic test_register_extremes();
		set_config(4095, 0, 1023, 65535, 255);
		set_config(0, 4095, 1, 0, 1);
		set_config(stdb_pkg::RST_SCALE_MIN, stdb_pkg::RST_SCALE_MAX, stdb_pkg::RST_REF_PPI,
			stdb_pkg::RST_DELAY, stdb_pkg::RST_MIN_CONFS);
	endtask

	task automatic test_field_extremes();
		send_scale_item(stdb_pkg::OP_OS, 12'd0, 12'd0, 14'd0, 12'd0);
		// tie sits exactly half a quarter up
		send_scale_item(stdb_pkg::OP_OS, 12'd288, 12'hFFF, 14'd0, 12'd0);
		send_scale_item(stdb_pkg::OP_OS, 12'hFFF, 12'd0, 14'h3FFF, 12'hFFF);
		send_scale_item(stdb_pkg::OP_OS, 12'd256, 12'd0, 14'd0, 12'd0);
		send_scale_item(stdb_pkg::OP_USER, 12'hFFF, 12'd0, 14'd0, 12'd0);
		send_scale_item(stdb_pkg::OP_USER, 12'd0, 12'hFFF, 14'h3FFF, 12'd49);
		send_scale_item(stdb_pkg::OP_USER, 12'd0, 12'd256, 14'd0, 12'd0);
		send_scale_item(stdb_pkg::OP_MEAS, 12'hFFF, 12'hFFF, 14'h3FFF, 12'd50);
		send_scale_item(stdb_pkg::OP_MEAS, 12'd0, 12'd0, 14'h3FFF, 12'd49);
		send_scale_item(stdb_pkg::OP_MEAS, 12'd0, 12'd0, 14'd1920, 12'hFFF);
		send_scale_item(stdb_pkg::OP_MEAS, 12'd0, 12'd0, 14'd3840, 12'd600);
		send_scale_item(stdb_pkg::OP_MEAS, 12'd0, 12'd0, 14'd3840, 12'd600);
		repeat (3) send_scale_item(stdb_pkg::OP_TICK, 12'hFFF, 12'hFFF, 14'h3FFF, 12'hFFF);
		send_scale_item(stdb_pkg::OP_MEAS, 12'd0, 12'd0, 14'd0, 12'd50);
		send_scale_item(stdb_pkg::OP_TICK, 12'd0, 12'd0, 14'd0, 12'd0);
	endtask

	task automatic test_debounce_rules();
		set_config(128, 1024, 96, 3, 2);
		send_scale_item(stdb_pkg::OP_MEAS, 12'd0, 12'd0, 14'd3840, 12'd600);
		repeat (3) send_random_item(stdb_pkg::OP_TICK);
		send_scale_item(stdb_pkg::OP_MEAS, 12'd0, 12'd0, 14'd3840, 12'd600);
		send_scale_item(stdb_pkg::OP_MEAS, 12'd0, 12'd0, 14'd2560, 12'd600);
		send_random_item(stdb_pkg::OP_TICK);
		send_scale_item(stdb_pkg::OP_MEAS, 12'd0, 12'd0, 14'd2560, 12'd600);
		send_scale_item(stdb_pkg::OP_MEAS, 12'd0, 12'd0, 14'd3000, 12'd600);
		repeat (4) send_random_item(stdb_pkg::OP_TICK);
		// zero confirmations act as one; a zero target still commits
		set_config(0, 0, 96, 0, 0);
		send_scale_item(stdb_pkg::OP_MEAS, 12'd0, 12'd0, 14'd3840, 12'd600);
		send_scale_item(stdb_pkg::OP_OS, 12'd512, 12'd0, 14'd0, 12'd0);
		// inverted bounds: the upper one wins
		set_config(4095, 100, 96, 1, 1);
		send_scale_item(stdb_pkg::OP_OS, 12'd300, 12'd0, 14'd0, 12'd0);
		send_scale_item(stdb_pkg::OP_MEAS, 12'd0, 12'd0, 14'd3840, 12'd600);
		// zero density saturates the physical scale
		set_config(0, 4095, 0, 2, 1);
		send_scale_item(stdb_pkg::OP_MEAS, 12'd0, 12'd0, 14'd0, 12'd50);
		repeat (2) send_random_item(stdb_pkg::OP_TICK);
		set_config(4095, 4095, 1023, 65535, 255);
		send_scale_item(stdb_pkg::OP_MEAS, 12'd0, 12'd0, 14'h3FFF, 12'd50);
		send_scale_item(stdb_pkg::OP_USER, 12'd0, 12'd100, 14'd0, 12'd0);
	endtask

	task automatic test_backpressure();
		set_config(128, 1024, 96, 1, 1);
		rx_hold_req = 400;
		repeat (6) begin
			send_scale_item(stdb_pkg::OP_MEAS, 12'd0, 12'd0,
				14'($urandom_range(1000, 6000)), 12'($urandom_range(50, 900)));
			send_random_item(stdb_pkg::OP_TICK);
		end
		wait_drain();
	endtask

	task automatic randomize_config();
		int smin, smax, ppi, delay, confs, pick;
		pick = $urandom_range(9);
		smin = (pick == 0) ? 0 : (pick == 1) ? 4095 : $urandom_range(32, 512);
		pick = $urandom_range(9);
		smax = (pick == 0) ? 4095 : (pick == 1) ? 0 : $urandom_range(512, 2048);
		pick = $urandom_range(9);
		ppi = (pick == 0) ? 0 : (pick == 1) ? 1023 : (pick == 2) ? 1 : $urandom_range(72, 200);
		pick = $urandom_range(9);
		delay = (pick == 0) ? $urandom_range(65535) : $urandom_range(6);
		pick = $urandom_range(9);
		confs = (pick == 0) ? $urandom_range(255) : $urandom_range(4);
		set_config(smin, smax, ppi, delay, confs);
	endtask

	// mostly confirm-and-age sequences on one geometry, the rest events and noise
	task automatic test_random_traffic(int count);
		int sent, kind, reps, ticks;
		logic [13:0] px;
		logic [11:0] mm;
		sent = 0;
		while (sent < count) begin
			kind = $urandom_range(99);
			px = 14'($urandom);
			mm = $urandom_range(1) ? 12'($urandom) : 12'($urandom_range(40, 900));
			if (kind < 60) begin
				reps = $urandom_range(1, 5);
				repeat (reps) begin
					send_scale_item(stdb_pkg::OP_MEAS, 12'($urandom), 12'($urandom), px, mm);
					ticks = $urandom_range(0, (cfg_delay > 8) ? 10 : cfg_delay + 2);
					repeat (ticks) send_random_item(stdb_pkg::OP_TICK);
					sent += 1 + ticks;
				end
				if ($urandom_range(19) == 0) wait_drain();
			end else if (kind < 72) begin
				send_scale_item(stdb_pkg::OP_OS, 12'($urandom), 12'($urandom), px, mm);
				sent++;
			end else if (kind < 84) begin
				send_scale_item(stdb_pkg::OP_USER, 12'($urandom), 12'($urandom), px, mm);
				sent++;
			end else begin
				send_random_item(stdb_pkg::op_t'($urandom_range(3)));
				sent++;
			end
		end
	endtask

	task automatic test_counter_limits();
		// confirmations saturate, then the delay releases the commit
		set_config(128, 1024, 96, 5, 255);
		repeat (260) send_scale_item(stdb_pkg::OP_MEAS, 12'd0, 12'd0, 14'd3840, 12'd600);
		repeat (5) send_random_item(stdb_pkg::OP_TICK);
	endtask

	initial begin
		reset_scale_state();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(32, 82);
		test_register_extremes();
		test_field_extremes();
		randomize_config();
		test_random_traffic(35);

		set_idling(82, 32);
		test_debounce_rules();
		randomize_config();
		test_random_traffic(35);

		set_idling(0, 0);
		test_backpressure();
		randomize_config();
		test_random_traffic(35);
		test_counter_limits();

		wait_drain();
		repeat (40) @(posedge clk);
		if (err_count == 0)
			$display("scale_target_debouncer_unit regression: pass");
		else
			$display("scale_target_debouncer_unit regression: fail");
		$finish;
	end

endmodule

### filelist.f
rtl/stdb_pkg.sv
rtl/stdb_fifo.sv
rtl/stdb_front.sv
rtl/stdb_div.sv
rtl/stdb_back.sv
rtl/scale_target_debouncer_unit.sv
verif/tb_scale_target_debouncer_unit.sv
